// File: hdl/arm_pkg.sv
// Shared types and constants of the alert record matcher.
package arm_pkg;

    localparam int RANK_W   = 8;
    localparam int TEMP_W   = 10;
    localparam int STAMP_W  = 32;
    localparam int WINDOW_W = 16;
    localparam int TOL_W    = 8;
    localparam int COUNT_W  = 16;
    localparam int VERDICT_W = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [VERDICT_W-1:0] VERDICT_NONE  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_TRUE  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_FALSE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TOL    = 8'd1;

    localparam logic [WINDOW_W-1:0] TIME_WINDOW_RESET = 16'd50;
    localparam logic [TOL_W-1:0]    TEMP_TOL_RESET    = 8'd5;
    localparam logic [COUNT_W-1:0]  COUNT_MAX         = 16'hFFFF;

    typedef struct packed {
        logic [RANK_W-1:0]         rank;
        logic signed [TEMP_W-1:0]  temp;
        logic [STAMP_W-1:0]        stamp;
    } record_t;

    typedef struct packed {
        logic store;
        logic load_alert;
        logic scan_run;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic scan_end;
        logic out_busy;
    } dp_status_t;

endpackage

// File: hdl/arm_alert_if.sv
// Input channel: reference records and alert checks.
interface arm_alert_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic [arm_pkg::RANK_W-1:0]           node_id;
    logic signed [arm_pkg::TEMP_W-1:0]    temperature;
    logic [arm_pkg::STAMP_W-1:0]          time_stamp;

    modport source (output valid, opcode, node_id, temperature, time_stamp, input ready);
    modport sink (input valid, opcode, node_id, temperature, time_stamp, output ready);
endinterface

// File: hdl/arm_result_if.sv
// Output channel: check verdicts with the matched record and counters.
interface arm_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [arm_pkg::VERDICT_W-1:0]        verdict;
    logic signed [arm_pkg::TEMP_W-1:0]    matched_temp;
    logic [arm_pkg::STAMP_W-1:0]          matched_time;
    logic [arm_pkg::COUNT_W-1:0]          true_total;
    logic [arm_pkg::COUNT_W-1:0]          false_total;

    modport source (output valid, verdict, matched_temp, matched_time, true_total,
                    false_total, input ready);
    modport sink (input valid, verdict, matched_temp, matched_time, true_total,
                  false_total, output ready);
endinterface

// File: hdl/arm_cfg_if.sv
// Configuration write channel.
interface arm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [arm_pkg::CFG_IDX_W-1:0]     index;
    logic [arm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/arm_ctrl.sv
// Controller state machine sequencing stores, scans and result commits.
module arm_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_opcode,
    output logic                 in_ready,
    input  arm_pkg::dp_status_t  status,
    output arm_pkg::dp_cmd_t     cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.store      = 1'b0;
        cmd.load_alert = 1'b0;
        cmd.scan_run   = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_opcode == arm_pkg::OP_STORE)
                    begin
                        cmd.store = 1'b1;
                    end
                    else
                    begin
                        cmd.load_alert = 1'b1;
                        state_next = status.empty ? ST_DECIDE : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (status.scan_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/arm_datapath.sv
// Record store, scan comparators, alert counters and result register.
module arm_datapath #(
    parameter int STORE_DEPTH = 128
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  arm_pkg::dp_cmd_t                      cmd,
    output arm_pkg::dp_status_t                   status,
    input  logic [arm_pkg::RANK_W-1:0]            node_id,
    input  logic signed [arm_pkg::TEMP_W-1:0]     temperature,
    input  logic [arm_pkg::STAMP_W-1:0]           time_stamp,
    input  logic                                  cfg_write,
    input  logic [arm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [arm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  result_ready,
    output logic                                  result_valid,
    output logic [arm_pkg::VERDICT_W-1:0]         verdict,
    output logic signed [arm_pkg::TEMP_W-1:0]     matched_temp,
    output logic [arm_pkg::STAMP_W-1:0]           matched_time,
    output logic [arm_pkg::COUNT_W-1:0]           true_total,
    output logic [arm_pkg::COUNT_W-1:0]           false_total
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);

    arm_pkg::record_t mem [STORE_DEPTH];
    arm_pkg::record_t rd_data_reg;

    logic [AW-1:0] write_slot_reg;
    logic [CW-1:0] fill_count_reg;
    logic [CW-1:0] issue_idx_reg;
    logic          eval_valid_reg;
    logic          eval_last_reg;
    logic          issue;

    logic [arm_pkg::RANK_W-1:0]          alert_rank_reg;
    logic signed [arm_pkg::TEMP_W-1:0]   alert_temp_reg;
    logic [arm_pkg::STAMP_W-1:0]         alert_time_reg;

    logic                                found_reg;
    logic signed [arm_pkg::TEMP_W-1:0]   mtemp_reg;
    logic [arm_pkg::STAMP_W-1:0]         mtime_reg;

    logic [arm_pkg::WINDOW_W-1:0]        time_window_reg;
    logic [arm_pkg::TOL_W-1:0]           temp_tol_reg;
    logic [arm_pkg::COUNT_W-1:0]         true_cnt_reg;
    logic [arm_pkg::COUNT_W-1:0]         true_cnt_next;
    logic [arm_pkg::COUNT_W-1:0]         false_cnt_reg;
    logic [arm_pkg::COUNT_W-1:0]         false_cnt_next;

    logic                                result_valid_reg;
    logic [arm_pkg::VERDICT_W-1:0]       verdict_reg;
    logic signed [arm_pkg::TEMP_W-1:0]   matched_temp_reg;
    logic [arm_pkg::STAMP_W-1:0]         matched_time_reg;

    logic                                rank_match;
    logic [arm_pkg::STAMP_W:0]           time_diff;
    logic                                is_current;
    logic                                hit;
    logic signed [arm_pkg::TEMP_W:0]     temp_diff;
    logic [arm_pkg::TEMP_W:0]            temp_abs;
    logic                                within_tol;
    logic [arm_pkg::VERDICT_W-1:0]       verdict_next;

    assign issue = cmd.scan_run && (issue_idx_reg < fill_count_reg);

    // The difference is taken over 33 bits so that a record newer than the
    // alert shows as negative and is therefore always current.
    assign rank_match = cmd.scan_run && eval_valid_reg && (rd_data_reg.rank == alert_rank_reg);
    assign time_diff  = {1'b0, alert_time_reg} - {1'b0, rd_data_reg.stamp};
    assign is_current = time_diff[arm_pkg::STAMP_W]
                     || (time_diff[arm_pkg::STAMP_W-1:0]
                         < {{(arm_pkg::STAMP_W - arm_pkg::WINDOW_W){1'b0}}, time_window_reg});
    assign hit        = rank_match && is_current;

    assign status.empty    = (fill_count_reg == '0);
    assign status.scan_end = cmd.scan_run && eval_valid_reg && (hit || eval_last_reg);
    assign status.out_busy = result_valid_reg && !result_ready;

    assign temp_diff  = {mtemp_reg[arm_pkg::TEMP_W-1], mtemp_reg}
                      - {alert_temp_reg[arm_pkg::TEMP_W-1], alert_temp_reg};
    assign temp_abs   = temp_diff[arm_pkg::TEMP_W] ? (~temp_diff + 1'b1) : temp_diff;
    assign within_tol = temp_abs <= {{(arm_pkg::TEMP_W + 1 - arm_pkg::TOL_W){1'b0}}, temp_tol_reg};

    always_comb
    begin
        true_cnt_next  = true_cnt_reg;
        false_cnt_next = false_cnt_reg;
        verdict_next   = arm_pkg::VERDICT_NONE;
        if (found_reg)
        begin
            if (within_tol)
            begin
                verdict_next = arm_pkg::VERDICT_TRUE;
                if (true_cnt_reg != arm_pkg::COUNT_MAX)
                begin
                    true_cnt_next = true_cnt_reg + 1'b1;
                end
            end
            else
            begin
                verdict_next = arm_pkg::VERDICT_FALSE;
                if (false_cnt_reg != arm_pkg::COUNT_MAX)
                begin
                    false_cnt_next = false_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Record store: one write port for stores, one registered read for scans.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[write_slot_reg] <= '{rank: node_id, temp: temperature, stamp: time_stamp};
        end
        if (issue)
        begin
            rd_data_reg <= mem[issue_idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            eval_last_reg <= ((issue_idx_reg + 1'b1) == fill_count_reg);
        end
        if (cmd.load_alert)
        begin
            alert_rank_reg <= node_id;
            alert_temp_reg <= temperature;
            alert_time_reg <= time_stamp;
        end
        if (rank_match)
        begin
            mtemp_reg <= rd_data_reg.temp;
            mtime_reg <= rd_data_reg.stamp;
        end
        if (cmd.commit)
        begin
            verdict_reg      <= verdict_next;
            matched_temp_reg <= found_reg ? mtemp_reg : '0;
            matched_time_reg <= found_reg ? mtime_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg   <= '0;
            fill_count_reg   <= '0;
            issue_idx_reg    <= '0;
            eval_valid_reg   <= 1'b0;
            found_reg        <= 1'b0;
            time_window_reg  <= arm_pkg::TIME_WINDOW_RESET;
            temp_tol_reg     <= arm_pkg::TEMP_TOL_RESET;
            true_cnt_reg     <= '0;
            false_cnt_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.store)
            begin
                write_slot_reg <= (write_slot_reg == AW'(STORE_DEPTH - 1))
                                ? '0 : write_slot_reg + 1'b1;
                if (fill_count_reg < CW'(STORE_DEPTH))
                begin
                    fill_count_reg <= fill_count_reg + 1'b1;
                end
            end

            if (cmd.load_alert)
            begin
                issue_idx_reg  <= '0;
                eval_valid_reg <= 1'b0;
                found_reg      <= 1'b0;
            end
            else
            begin
                eval_valid_reg <= issue;
                if (issue)
                begin
                    issue_idx_reg <= issue_idx_reg + 1'b1;
                end
                if (rank_match)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    arm_pkg::CFG_TIME_WINDOW: time_window_reg <= cfg_data;
                    arm_pkg::CFG_TEMP_TOL:    temp_tol_reg <= cfg_data[arm_pkg::TOL_W-1:0];
                    default:                  ;
                endcase
            end

            if (cmd.commit)
            begin
                true_cnt_reg     <= true_cnt_next;
                false_cnt_reg    <= false_cnt_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign verdict      = verdict_reg;
    assign matched_temp = matched_temp_reg;
    assign matched_time = matched_time_reg;
    assign true_total   = true_cnt_reg;
    assign false_total  = false_cnt_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CW'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_count_reg < CW'(STORE_DEPTH)) |-> (CW'(write_slot_reg) == fill_count_reg))
        else $error("write slot out of step with fill count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(result_valid_reg && !result_ready))
        else $error("result committed over an untaken result");

    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(cmd.commit))
        else $error("result shown without a commit");

    a_true_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (true_cnt_reg >= $past(true_cnt_reg)))
        else $error("true alert counter decreased");
`endif

endmodule

// File: hdl/alert_record_matcher_core.sv
// Top level of the alert record matcher: controller, datapath and channels.
//
// Usage. The alert channel carries two kinds of item. A store item (opcode 0)
// writes a reference record into the next slot of a ring of STORE_DEPTH
// entries and yields no result. A check item (opcode 1) scans the filled
// slots in order for the alert's node rank and yields exactly one item on the
// result channel: the verdict, the matched record and the true and false alert
// totals after this check. The scan reads the record store through its single
// read port, one slot per cycle, and stops at the first current record of the
// alert's rank or after the last filled slot; on an empty store no slot is
// read. One item is worked on at a time; alert.ready is high only while the
// block is between items.
// The result sits in an output register, so a new item is accepted while the
// previous result waits. If the receiver stalls, a second check completes its
// scan and then holds until the first result has been taken.
// Configuration writes are taken in any cycle (cfg.ready is always high) and
// must be made while no item is in flight. Reset empties the store, clears
// the counters and loads the register defaults; no clearing pass is needed.
module alert_record_matcher_core #(
    parameter int STORE_DEPTH = 128
)
(
    input  logic          clk,
    input  logic          rst_n,
    arm_alert_if.sink     alert,
    arm_result_if.source  result,
    arm_cfg_if.sink       cfg
);

    arm_pkg::dp_cmd_t     cmd;
    arm_pkg::dp_status_t  status;

    assign cfg.ready = 1'b1;

    arm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (alert.valid),
        .in_opcode (alert.opcode),
        .in_ready  (alert.ready),
        .status    (status),
        .cmd       (cmd)
    );

    arm_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .node_id      (alert.node_id),
        .temperature  (alert.temperature),
        .time_stamp   (alert.time_stamp),
        .cfg_write    (cfg.valid && cfg.ready),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .verdict      (result.verdict),
        .matched_temp (result.matched_temp),
        .matched_time (result.matched_time),
        .true_total   (result.true_total),
        .false_total  (result.false_total)
    );

endmodule
